/* rtl/core/dh_forward_kinematics_chain_defines.svh */
// assertion macros for the kinematics chain
`ifndef DH_FORWARD_KINEMATICS_CHAIN_DEFINES_SVH
`define DH_FORWARD_KINEMATICS_CHAIN_DEFINES_SVH
`ifndef ASSERT_OFF
`define DHK_ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DHK_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define DHK_ASSERT_IMPL(label, clk, rst, prop, msg)
`define DHK_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* rtl/core/dhk_pkg.sv */
package dhk_pkg;

  localparam int NUM_LINKS = 4;
  localparam int GEOM_REGS = 4;
  localparam int CORDIC_STEPS = 16;

  localparam logic signed [15:0] Q14_ONE = 16'sd16384;
  localparam logic signed [19:0] PI_U16 = 20'sd205887;
  localparam logic signed [19:0] HALF_PI_U16 = 20'sd102944;
  localparam logic signed [19:0] TWO_PI_U16 = 20'sd411775;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [19:0] POS_MAX = 20'sd524287;
  localparam logic signed [19:0] POS_MIN = 20'sh80000;

  typedef struct packed {
    logic signed [15:0] joint_angle;
    logic [1:0]         link_index;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] rot_00;
    logic signed [15:0] rot_01;
    logic signed [15:0] rot_02;
    logic signed [15:0] rot_10;
    logic signed [15:0] rot_11;
    logic signed [15:0] rot_12;
    logic signed [15:0] rot_20;
    logic signed [15:0] rot_21;
    logic signed [15:0] rot_22;
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic signed [19:0] pos_z;
  } out_word_t;

  // controller commands to the datapath
  typedef struct packed {
    logic load;        // capture input word and geometry
    logic cordic_joint; // start cordic on joint angle
    logic cordic_twist; // start cordic on twist
    logic build;       // form link transform terms
    logic mac_start;   // start matrix product
    logic commit;      // write new pose into chain state
  } dhk_cmd_t;

  typedef struct packed {
    logic cordic_done;
    logic mac_done;
  } dhk_sts_t;

  function automatic logic [19:0] atan_entry(input logic [3:0] i);
    case (i)
      4'd0: atan_entry = 20'd51472;
      4'd1: atan_entry = 20'd30386;
      4'd2: atan_entry = 20'd16055;
      4'd3: atan_entry = 20'd8150;
      4'd4: atan_entry = 20'd4091;
      4'd5: atan_entry = 20'd2047;
      4'd6: atan_entry = 20'd1024;
      4'd7: atan_entry = 20'd512;
      4'd8: atan_entry = 20'd256;
      4'd9: atan_entry = 20'd128;
      4'd10: atan_entry = 20'd64;
      4'd11: atan_entry = 20'd32;
      4'd12: atan_entry = 20'd16;
      4'd13: atan_entry = 20'd8;
      4'd14: atan_entry = 20'd4;
      4'd15: atan_entry = 20'd2;
      default: atan_entry = 20'd0;
    endcase
  endfunction

  // round a value with 14 fractional bits, half up
  function automatic logic signed [35:0] rnd14(input logic signed [35:0] v);
    rnd14 = (v + 36'sd8192) >>> 14;
  endfunction

  function automatic logic signed [15:0] clamp_q14(input logic signed [35:0] v);
    if (v > 36'sd16384) clamp_q14 = Q14_ONE;
    else if (v < -36'sd16384) clamp_q14 = -Q14_ONE;
    else clamp_q14 = v[15:0];
  endfunction

endpackage

/* rtl/core/dhk_cordic.sv */
// iterative sine / cosine, one micro-rotation per cycle
module dhk_cordic import dhk_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [16:0] angle,
  output logic               done,
  output logic signed [15:0] sin_q,
  output logic signed [15:0] cos_q
);

  logic signed [33:0] x, y;
  logic signed [20:0] z;
  logic [3:0]         step;
  logic               busy;
  logic               neg;

  logic signed [20:0] z_wrap, z_fold;
  logic               fold_neg;
  logic signed [33:0] x_rnd, y_rnd;
  logic signed [15:0] x_cl, y_cl;

  // range reduction into [-pi/2, pi/2]
  always_comb begin
    z_wrap = 21'(angle) * 21'sd8;
    if (z_wrap > 21'(PI_U16)) z_wrap = z_wrap - 21'(TWO_PI_U16);
    else if (z_wrap < -21'(PI_U16)) z_wrap = z_wrap + 21'(TWO_PI_U16);
    fold_neg = 1'b0;
    z_fold = z_wrap;
    if (z_wrap > 21'(HALF_PI_U16)) begin
      z_fold = z_wrap - 21'(PI_U16);
      fold_neg = 1'b1;
    end else if (z_wrap < -21'(HALF_PI_U16)) begin
      z_fold = z_wrap + 21'(PI_U16);
      fold_neg = 1'b1;
    end
  end

  // micro-rotation iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        x <= CORDIC_GAIN;
        y <= '0;
        z <= z_fold;
        neg <= fold_neg;
      end else if (busy) begin
        if (z >= 0) begin
          x <= x - (y >>> step);
          y <= y + (x >>> step);
          z <= z - 21'(signed'({1'b0, atan_entry(step)}));
        end else begin
          x <= x + (y >>> step);
          y <= y - (x >>> step);
          z <= z + 21'(signed'({1'b0, atan_entry(step)}));
        end
        step <= step + 4'd1;
        if (step == 4'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // round to q1.14 and clamp
  always_comb begin
    x_rnd = (x + 34'sd32768) >>> 16;
    y_rnd = (y + 34'sd32768) >>> 16;
    x_cl = clamp_q14(36'(x_rnd));
    y_cl = clamp_q14(36'(y_rnd));
    cos_q = neg ? -x_cl : x_cl;
    sin_q = neg ? -y_cl : y_cl;
  end

endmodule

/* rtl/core/dhk_datapath.sv */
// link transform build and shared multiply-accumulate over the chain pose
module dhk_datapath import dhk_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  dhk_cmd_t        cmd,
  output dhk_sts_t        sts,
  input  in_word_t        in_word,
  input  logic [63:0]     geom [GEOM_REGS],
  output out_word_t       pose
);

  logic signed [15:0] chain_rotation [9];
  logic signed [19:0] chain_translation [3];
  logic signed [15:0] new_rot [9];
  logic signed [19:0] new_trans [3];

  logic [1:0]         link;
  logic signed [15:0] la, ld, lal, loff, jang;
  logic signed [15:0] s, c, sa, ca;
  logic signed [15:0] ar [9];
  logic signed [16:0] at [3];

  logic               cstart;
  logic signed [16:0] cangle;
  logic               cdone;
  logic signed [15:0] csin, ccos;

  // mac sequencing: 12 outputs by 3 terms
  logic [3:0]         mac_out;
  logic [1:0]         mac_term;
  logic [1:0]         mac_row;
  logic [1:0]         mac_col;
  logic               mac_busy;
  logic               mac_done;
  logic signed [35:0] acc;
  logic signed [31:0] prod;
  logic signed [15:0] opa;
  logic signed [16:0] opb;
  logic [1:0]         row;
  logic [1:0]         col;
  logic               is_trans;
  logic signed [35:0] acc_sum;
  logic signed [35:0] acc_r;
  logic signed [21:0] t_sum;
  logic signed [31:0] bprod [6];

  logic [3:0] ridx, aidx;

  dhk_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cstart),
    .angle (cangle),
    .done  (cdone),
    .sin_q (csin),
    .cos_q (ccos)
  );

  assign cstart = cmd.cordic_joint | cmd.cordic_twist;
  assign cangle = cmd.cordic_twist ? 17'(lal) : 17'(jang) + 17'(loff);
  assign sts = '{cordic_done: cdone, mac_done: mac_done};

  // capture word, geometry, and cordic results
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      link <= in_word.link_index;
      jang <= in_word.joint_angle;
      la   <= geom[in_word.link_index][15:0];
      ld   <= geom[in_word.link_index][31:16];
      lal  <= geom[in_word.link_index][47:32];
      loff <= geom[in_word.link_index][63:48];
    end
    if (cmd.cordic_twist) begin
      s <= csin;
      c <= ccos;
    end
  end

  assign sa = csin;
  assign ca = ccos;

  // products of the link transform
  always_comb begin
    bprod[0] = s * ca;
    bprod[1] = s * sa;
    bprod[2] = c * ca;
    bprod[3] = c * sa;
    bprod[4] = la * c;
    bprod[5] = la * s;
  end

  // build link transform (twist results still held at cordic output)
  always_ff @(posedge clk) begin
    if (cmd.build) begin
      ar[0] <= c;
      ar[1] <= 16'(-rnd14(36'(bprod[0])));
      ar[2] <= 16'(rnd14(36'(bprod[1])));
      ar[3] <= s;
      ar[4] <= 16'(rnd14(36'(bprod[2])));
      ar[5] <= 16'(-rnd14(36'(bprod[3])));
      ar[6] <= '0;
      ar[7] <= sa;
      ar[8] <= ca;
      at[0] <= 17'(rnd14(36'(bprod[4])));
      at[1] <= 17'(rnd14(36'(bprod[5])));
      at[2] <= 17'(ld);
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    is_trans = (mac_out >= 4'd9);
    row = mac_row;
    col = mac_col;
    ridx = 4'(row) * 4'd3 + 4'(mac_term);
    aidx = 4'(mac_term) * 4'd3 + 4'(col);
    if (link == 2'd0) opa = (row == mac_term) ? Q14_ONE : 16'sd0;
    else opa = chain_rotation[ridx];
    opb = is_trans ? at[mac_term] : 17'(ar[aidx]);
    acc_sum = acc + 36'(prod);
    acc_r = rnd14(acc_sum);
    if (link == 2'd0) t_sum = 22'(acc_r);
    else t_sum = 22'(acc_r) + 22'(chain_translation[row]);
  end

  // multiply-accumulate, registered product; each product is accumulated before the next is formed
  logic prod_vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      mac_busy <= 1'b0;
      prod_vld <= 1'b0;
      mac_done <= 1'b0;
      mac_out <= '0;
      mac_term <= '0;
      mac_row <= '0;
      mac_col <= '0;
    end else begin
      mac_done <= 1'b0;
      if (cmd.mac_start) begin
        mac_busy <= 1'b1;
        prod_vld <= 1'b0;
        mac_out <= '0;
        mac_term <= '0;
        mac_row <= '0;
        mac_col <= '0;
        acc <= '0;
      end else if (mac_busy) begin
        if (!prod_vld) begin
          prod <= opa * opb;
          prod_vld <= 1'b1;
        end else begin
          prod_vld <= 1'b0;
          if (mac_term == 2'd2) begin
            acc <= '0;
            mac_term <= '0;
            if (is_trans) begin
              if (t_sum > 22'(POS_MAX)) new_trans[row] <= POS_MAX;
              else if (t_sum < 22'(POS_MIN)) new_trans[row] <= POS_MIN;
              else new_trans[row] <= t_sum[19:0];
            end else begin
              new_rot[mac_out] <= clamp_q14(acc_r);
            end
            // step row and column of the next pose term
            if (is_trans || mac_col == 2'd2) begin
              mac_col <= '0;
              mac_row <= (mac_row == 2'd2) ? 2'd0 : mac_row + 2'd1;
            end else begin
              mac_col <= mac_col + 2'd1;
            end
            if (mac_out == 4'd11) begin
              mac_busy <= 1'b0;
              mac_done <= 1'b1;
            end
            mac_out <= mac_out + 4'd1;
          end else begin
            acc <= acc_sum;
            mac_term <= mac_term + 2'd1;
          end
        end
      end
    end
  end

  // chain state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 9; k++)
        chain_rotation[k] <= (k % 4 == 0) ? Q14_ONE : 16'sd0;
      for (int k = 0; k < 3; k++)
        chain_translation[k] <= '0;
    end else if (cmd.commit) begin
      chain_rotation <= new_rot;
      chain_translation <= new_trans;
    end
  end

  assign pose = '{chain_rotation[0], chain_rotation[1], chain_rotation[2],
                  chain_rotation[3], chain_rotation[4], chain_rotation[5],
                  chain_rotation[6], chain_rotation[7], chain_rotation[8],
                  chain_translation[0], chain_translation[1],
                  chain_translation[2]};

endmodule

/* rtl/core/dhk_ctrl.sv */
`include "dh_forward_kinematics_chain_defines.svh"
// sequencer for one joint word
module dhk_ctrl import dhk_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output logic     out_load,
  output dhk_cmd_t cmd,
  input  dhk_sts_t sts
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_JNT   = 7'b0000010,
    S_JWAIT = 7'b0000100,
    S_TWAIT = 7'b0001000,
    S_BUILD = 7'b0010000,
    S_MAC   = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state, state_next;

  // the output register frees as soon as its word is taken
  logic out_free;
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    out_load = 1'b0;
    case (state)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        state_next = S_JNT;
      end
      S_JNT: begin
        cmd.cordic_joint = 1'b1;
        state_next = S_JWAIT;
      end
      S_JWAIT: if (sts.cordic_done) begin
        cmd.cordic_twist = 1'b1;
        state_next = S_TWAIT;
      end
      S_TWAIT: if (sts.cordic_done) begin
        cmd.build = 1'b1;
        state_next = S_BUILD;
      end
      S_BUILD: begin
        cmd.mac_start = 1'b1;
        state_next = S_MAC;
      end
      S_MAC: if (sts.mac_done) begin
        cmd.commit = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: if (out_free) begin
        out_load = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  `DHK_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, in_valid && !in_stall, state == S_JNT, "accept did not start work")
  `DHK_ASSERT_NEXT(a_out_held, clk, rst, out_valid && out_stall, out_valid, "stalled word dropped")
  `DHK_ASSERT_NEXT(a_commit_then_done, clk, rst, cmd.commit, state == S_DONE, "commit out of order")
  `DHK_ASSERT_IMPL(a_load_only_idle, clk, rst, cmd.load |-> state == S_IDLE, "load outside idle")

endmodule

/* rtl/core/dh_forward_kinematics_chain.sv */
// flow: an accepted word runs two cordic passes (joint angle, then twist), the link build,
// then 12 pose terms of 3 products each through the shared multiplier before out_valid rises;
// a new word is taken only once the previous pose word has been loaded for output, and
// a held pose word keeps the next word waiting in the controller
// reset: synchronous; pose returns to identity, geometry registers to zero
module dh_forward_kinematics_chain import dhk_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0] geom [GEOM_REGS];
  dhk_cmd_t    cmd;
  dhk_sts_t    sts;
  logic        out_load;
  out_word_t   pose;

  // geometry registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < GEOM_REGS; k++) geom[k] <= '0;
    end else if (cfg_we) begin
      geom[cfg_index] <= cfg_data;
    end
  end

  dhk_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_load  (out_load),
    .cmd       (cmd),
    .sts       (sts)
  );

  dhk_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .sts     (sts),
    .in_word (in_data),
    .geom    (geom),
    .pose    (pose)
  );

  // output word register
  always_ff @(posedge clk) begin
    if (out_load) out_data <= pose;
  end

endmodule

/* dv/dh_forward_kinematics_chain_tb.sv */
`timescale 1ns / 100ps

module dh_forward_kinematics_chain_tb;
  import dhk_pkg::*;

  typedef enum logic [1:0] {
    GEOM_LINK0 = 2'd0,
    GEOM_LINK1 = 2'd1,
    GEOM_LINK2 = 2'd2,
    GEOM_LINK3 = 2'd3
  } geom_reg_t;

  localparam int LATENCY = 60;
  localparam longint CYCLE_LIMIT = 1200000;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;

  dh_forward_kinematics_chain u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state
  logic [63:0]     geom_shadow [4];
  longint          pose_rot [9];
  longint          pose_pos [3];
  out_word_t       pose_queue [$];
  int              mismatch_count;
  longint          cycle_count;
  bit              idle_enable;
  bit              hold_off;
  int              hold_cycles;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // cordic sine and cosine of a q3.13 angle, result q1.14
  task automatic sin_cos(input longint ang, output longint sn, output longint cs);
    longint z, x, y, dx, dy;
    bit flip;
    longint atans [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                           256, 128, 64, 32, 16, 8, 4, 2};
    z = ang * 8;
    x = 652032874;
    y = 0;
    flip = 0;
    while (z > 205887) z -= 411775;
    while (z < -205887) z += 411775;
    if (z > 102944) begin
      z -= 205887;
      flip = 1;
    end else if (z < -102944) begin
      z += 205887;
      flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atans[i];
      end else begin
        x += dx; y -= dy; z += atans[i];
      end
    end
    x = clip(round_shift(x, 16), -16384, 16384);
    y = clip(round_shift(y, 16), -16384, 16384);
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endtask

  function automatic void reset_pose();
    for (int k = 0; k < 9; k++) pose_rot[k] = (k % 4 == 0) ? 16384 : 0;
    for (int k = 0; k < 3; k++) pose_pos[k] = 0;
  endfunction

  // apply one link transform onto the cumulative pose
  task automatic advance_pose(input in_word_t w);
    logic [63:0] g;
    longint la, ld, lal, loff, s, c, sa, ca, acc;
    longint lr [9];
    longint lt [3];
    longint nr [9];
    longint nt [3];
    out_word_t exp_w;
    g = geom_shadow[w.link_index];
    la = longint'($signed(g[15:0]));
    ld = longint'($signed(g[31:16]));
    lal = longint'($signed(g[47:32]));
    loff = longint'($signed(g[63:48]));
    if (w.link_index == 0) reset_pose();
    sin_cos(longint'(w.joint_angle) + loff, s, c);
    sin_cos(lal, sa, ca);
    lr[0] = c; lr[1] = -round_shift(s * ca, 14); lr[2] = round_shift(s * sa, 14);
    lr[3] = s; lr[4] = round_shift(c * ca, 14);  lr[5] = -round_shift(c * sa, 14);
    lr[6] = 0; lr[7] = sa; lr[8] = ca;
    lt[0] = round_shift(la * c, 14);
    lt[1] = round_shift(la * s, 14);
    lt[2] = ld;
    for (int r = 0; r < 3; r++) begin
      for (int col = 0; col < 3; col++) begin
        acc = 0;
        for (int j = 0; j < 3; j++) acc += pose_rot[r*3+j] * lr[j*3+col];
        nr[r*3+col] = clip(round_shift(acc, 14), -16384, 16384);
      end
      acc = 0;
      for (int j = 0; j < 3; j++) acc += pose_rot[r*3+j] * lt[j];
      nt[r] = clip(round_shift(acc, 14) + pose_pos[r], -524288, 524287);
    end
    pose_rot = nr;
    pose_pos = nt;
    exp_w.rot_00 = 16'(pose_rot[0]); exp_w.rot_01 = 16'(pose_rot[1]);
    exp_w.rot_02 = 16'(pose_rot[2]);
    exp_w.rot_10 = 16'(pose_rot[3]); exp_w.rot_11 = 16'(pose_rot[4]);
    exp_w.rot_12 = 16'(pose_rot[5]);
    exp_w.rot_20 = 16'(pose_rot[6]); exp_w.rot_21 = 16'(pose_rot[7]);
    exp_w.rot_22 = 16'(pose_rot[8]);
    exp_w.pos_x = 20'(pose_pos[0]); exp_w.pos_y = 20'(pose_pos[1]);
    exp_w.pos_z = 20'(pose_pos[2]);
    pose_queue.push_back(exp_w);
  endtask

  // send one word, sometimes with a random gap before it
  task automatic send_word(input logic signed [15:0] ang, input logic [1:0] link);
    in_word_t w;
    w.joint_angle = ang;
    w.link_index = link;
    if (idle_enable && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(10, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_pose(w);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pose_queue.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_geom(input geom_reg_t idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    geom_shadow[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] pack_geom(logic signed [15:0] a, logic signed [15:0] d,
                                            logic signed [15:0] alpha,
                                            logic signed [15:0] off);
    return {off, alpha, d, a};
  endfunction

  // random angle, biased towards extremes now and then
  function automatic logic signed [15:0] rand_angle();
    case ($urandom_range(7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst && out_valid && !out_stall) begin
      if (pose_queue.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected pose word %h", out_data);
      end else begin
        exp_w = pose_queue.pop_front();
        if (out_data !== exp_w) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("pose mismatch: expected %h got %h", exp_w, out_data);
        end
      end
    end
  end

  // receiver stall: random bursts, or a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_cycles <= 0;
    end else if (hold_off) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles + 1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= idle_enable && (hold_cycles % 3 == 0);
    end else if (idle_enable && $urandom_range(5) == 0) begin
      out_stall <= 1'b1;
      hold_cycles <= $urandom_range(10, 1);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic test_directed();
    // neutral geometry: plain rotations about z
    write_geom(GEOM_LINK0, 64'd0);
    send_word(16'sd0, 2'd0);
    send_word(16'sh7fff, 2'd1);
    send_word(16'sh8000, 2'd2);
    send_word(16'sd12868, 2'd3);
    send_word(-16'sd12868, 2'd3);
    wait_drained();
    // full-scale lengths, twists and offsets to push saturation
    write_geom(GEOM_LINK0, pack_geom(16'sh7fff, 16'sh7fff, 16'sd12868, 16'sh7fff));
    write_geom(GEOM_LINK1, pack_geom(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000));
    write_geom(GEOM_LINK2, pack_geom(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sd0));
    write_geom(GEOM_LINK3, pack_geom(16'sh7fff, 16'sh7fff, -16'sd12868, 16'sh8000));
    send_word(16'sh7fff, 2'd0);
    for (int k = 0; k < 12; k++) send_word(16'sh7fff, 2'(1 + k % 3));
    send_word(16'sh8000, 2'd0);
    for (int k = 0; k < 6; k++) send_word(16'sh8000, 2'(1 + k % 3));
    wait_drained();
  endtask

  task automatic test_arm_chains(input int n);
    // a typical arm, then mostly well-formed chains 0..3 with noise
    write_geom(GEOM_LINK0, pack_geom(16'sd0, 16'sd2130, -16'sd12868, 16'sd0));
    write_geom(GEOM_LINK1, pack_geom(16'sd2130, 16'sd0, 16'sd0, -16'sd1547));
    write_geom(GEOM_LINK2, pack_geom(16'sd2032, 16'sd0, 16'sd0, 16'sd11321));
    write_geom(GEOM_LINK3, pack_geom(16'sd1229, 16'sd0, 16'sd0, 16'sd0));
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(4) == 0) send_word(rand_angle(), 2'($urandom_range(3)));
      else send_word(rand_angle(), 2'(k % 4));
    end
    wait_drained();
  endtask

  task automatic test_random_geometry(input int phases, input int n);
    for (int p = 0; p < phases; p++) begin
      for (int r = 0; r < 4; r++) write_geom(geom_reg_t'(r), {$urandom, $urandom});
      for (int k = 0; k < n; k++) send_word(rand_angle(), 2'($urandom_range(3)));
      wait_drained();
    end
  endtask

  task automatic test_backpressure();
    // receiver holds off while the sender keeps offering
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      for (int k = 0; k < 12; k++) send_word(rand_angle(), 2'(k % 4));
    join
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatch_count = 0;
    cycle_count = 0;
    idle_enable = 1;
    hold_off = 0;
    for (int r = 0; r < 4; r++) geom_shadow[r] = '0;
    reset_pose();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_arm_chains(500);
    test_backpressure();
    test_random_geometry(6, 100);
    idle_enable = 0;
    test_arm_chains(300);

    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
